/* design/i2cm_pkg.sv */
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT_TICKS = 2'd2;

    localparam logic [6:0] RST_DEVICE_ADDRESS    = 7'd104;
    localparam logic [7:0] RST_HALF_PERIOD_TICKS = 8'd5;
    localparam logic [7:0] RST_ACK_TIMEOUT_TICKS = 8'd200;

    // Command codes
    localparam logic [1:0] MODE_NONE      = 2'd0;
    localparam logic [1:0] MODE_WRITE     = 2'd1;
    localparam logic [1:0] MODE_READ      = 2'd2;
    localparam logic [1:0] MODE_READ_PAIR = 2'd3;

    // Byte sequence within one register access
    localparam logic [1:0] STAGE_ADDR_W = 2'd0;
    localparam logic [1:0] STAGE_REG    = 2'd1;
    localparam logic [1:0] STAGE_DATA   = 2'd2;

    localparam logic [7:0] MSB_MASK         = 8'h80;
    localparam logic [8:0] NACK_SETUP_TICKS = 9'd2;
    localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] half_period_ticks;
        logic [7:0] ack_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_oe;
        logic        busy_res;
        logic        done_res;
        logic        status;
        logic [15:0] read_data;
    } t_result;

endpackage

/* design/i2cm_cfg.sv */
// Configuration registers of the I2C register access master.
module i2cm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output i2cm_pkg::t_cfg                      o_cfg
);

    i2cm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address    <= i2cm_pkg::RST_DEVICE_ADDRESS;
            r_cfg.half_period_ticks <= i2cm_pkg::RST_HALF_PERIOD_TICKS;
            r_cfg.ack_timeout_ticks <= i2cm_pkg::RST_ACK_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cm_pkg::CFG_DEVICE_ADDRESS:    r_cfg.device_address    <= i_cfg_wdata[6:0];
                i2cm_pkg::CFG_HALF_PERIOD_TICKS: r_cfg.half_period_ticks <= i_cfg_wdata;
                i2cm_pkg::CFG_ACK_TIMEOUT_TICKS: r_cfg.ack_timeout_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/i2cm_seq.sv */
// Bus sequencer: advances the I2C transfer by one tick per item.
module i2cm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cm_pkg::t_item     i_item,
    input  i2cm_pkg::t_cfg      i_cfg,
    output i2cm_pkg::t_result   o_res
);

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_TX_HI   = 5'd3,
        PH_TX_LO   = 5'd4,
        PH_AK_REL  = 5'd5,
        PH_AK_HI   = 5'd6,
        PH_AK_POLL = 5'd7,
        PH_AK_LO   = 5'd8,
        PH_RX_HI   = 5'd9,
        PH_RX_LO   = 5'd10,
        PH_NK_SET  = 5'd11,
        PH_NK_HI   = 5'd12,
        PH_NK_LO   = 5'd13,
        PH_SP_PRE  = 5'd14,
        PH_SP_A    = 5'd15,
        PH_SP_B    = 5'd16
    } t_phase;

    t_phase      r_phase,          n_phase;
    logic [3:0]  r_bit_index,      n_bit_index;
    logic [7:0]  r_shift_byte,     n_shift_byte;
    logic [7:0]  r_delay_count,    n_delay_count;
    logic [7:0]  r_ack_wait_count, n_ack_wait_count;
    logic [15:0] r_data_hold,      n_data_hold;
    logic [1:0]  r_held_mode,      n_held_mode;
    logic [7:0]  r_held_register,  n_held_register;
    logic [7:0]  r_held_write_byte, n_held_write_byte;
    logic        r_pair_second,    n_pair_second;
    logic [1:0]  r_byte_stage,     n_byte_stage;
    logic        r_fail_flag,      n_fail_flag;

    logic [7:0]  hp;
    logic [8:0]  tick_next;
    logic        hp_hit;
    logic        nk_hit;
    logic        tx_bit;
    logic [3:0]  bit_inc;
    i2cm_pkg::t_result res;

    assign hp        = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign tick_next = {1'b0, r_delay_count} + 9'd1;
    assign hp_hit    = tick_next >= {1'b0, hp};
    assign nk_hit    = tick_next >= i2cm_pkg::NACK_SETUP_TICKS;
    assign tx_bit    = |(r_shift_byte & i2cm_pkg::MSB_MASK);
    assign bit_inc   = r_bit_index + 4'd1;

    always_comb begin
        n_phase           = r_phase;
        n_bit_index       = r_bit_index;
        n_shift_byte      = r_shift_byte;
        n_delay_count     = r_delay_count;
        n_ack_wait_count  = r_ack_wait_count;
        n_data_hold       = r_data_hold;
        n_held_mode       = r_held_mode;
        n_held_register   = r_held_register;
        n_held_write_byte = r_held_write_byte;
        n_pair_second     = r_pair_second;
        n_byte_stage      = r_byte_stage;
        n_fail_flag       = r_fail_flag;

        res           = '0;
        res.scl       = 1'b1;
        res.sda_out   = 1'b1;
        res.sda_oe    = 1'b1;
        res.busy_res  = (r_phase != PH_IDLE);

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.mode != i2cm_pkg::MODE_NONE) begin
                    n_held_mode       = i_item.mode;
                    n_held_register   = i_item.reg_addr;
                    n_held_write_byte = i_item.write_data;
                    n_pair_second     = 1'b0;
                    n_data_hold       = '0;
                    n_fail_flag       = 1'b0;
                    n_byte_stage      = i2cm_pkg::STAGE_ADDR_W;
                    n_phase           = PH_ST_A;
                    n_delay_count     = '0;
                end
            end
            PH_ST_A: begin
                if (hp_hit) begin
                    n_phase = PH_ST_B; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_ST_B: begin
                res.sda_out = 1'b0;
                if (hp_hit) begin
                    n_shift_byte  = {i_cfg.device_address,
                                     r_byte_stage == i2cm_pkg::STAGE_DATA};
                    n_bit_index   = '0;
                    n_phase       = PH_TX_HI;
                    n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_TX_HI: begin
                res.sda_out = tx_bit;
                if (hp_hit) begin
                    n_phase = PH_TX_LO; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_TX_LO: begin
                res.scl     = 1'b0;
                res.sda_out = tx_bit;
                if (hp_hit) begin
                    n_shift_byte  = {r_shift_byte[6:0], 1'b0};
                    n_bit_index   = bit_inc;
                    n_phase       = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ? PH_AK_REL : PH_TX_HI;
                    n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_AK_REL: begin
                res.scl = 1'b0;
                if (hp_hit) begin
                    n_phase = PH_AK_HI; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_AK_HI: begin
                res.sda_oe = 1'b0;
                if (hp_hit) begin
                    n_ack_wait_count = '0;
                    n_phase          = PH_AK_POLL;
                    n_delay_count    = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_AK_POLL: begin
                res.sda_oe = 1'b0;
                if (!i_item.sda_in) begin
                    n_phase = PH_AK_LO; n_delay_count = '0;
                end else if (r_ack_wait_count >= i_cfg.ack_timeout_ticks) begin
                    n_fail_flag = 1'b1;
                    if (r_held_mode != i2cm_pkg::MODE_WRITE)
                        n_data_hold = {r_data_hold[7:0], 8'h00};
                    n_phase       = PH_SP_PRE;
                    n_delay_count = '0;
                end else begin
                    n_ack_wait_count = r_ack_wait_count + 8'd1;
                end
            end
            PH_AK_LO: begin
                res.scl    = 1'b0;
                res.sda_oe = 1'b0;
                if (hp_hit) begin
                    n_delay_count = '0;
                    if (r_byte_stage == i2cm_pkg::STAGE_ADDR_W) begin
                        n_byte_stage = i2cm_pkg::STAGE_REG;
                        n_shift_byte = r_held_register;
                        n_bit_index  = '0;
                        n_phase      = PH_TX_HI;
                    end else if (r_byte_stage == i2cm_pkg::STAGE_REG) begin
                        n_byte_stage = i2cm_pkg::STAGE_DATA;
                        if (r_held_mode == i2cm_pkg::MODE_WRITE) begin
                            n_shift_byte = r_held_write_byte;
                            n_bit_index  = '0;
                            n_phase      = PH_TX_HI;
                        end else begin
                            n_phase = PH_ST_A;  // repeated start
                        end
                    end else if (r_held_mode == i2cm_pkg::MODE_WRITE) begin
                        n_phase = PH_SP_PRE;
                    end else begin
                        n_shift_byte = '0;
                        n_bit_index  = '0;
                        n_phase      = PH_RX_HI;
                    end
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_RX_HI: begin
                res.sda_oe = 1'b0;
                if (hp_hit) begin
                    n_shift_byte  = {r_shift_byte[6:0], i_item.sda_in};
                    n_phase       = PH_RX_LO;
                    n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_RX_LO: begin
                res.scl    = 1'b0;
                res.sda_oe = 1'b0;
                if (hp_hit) begin
                    n_bit_index   = bit_inc;
                    n_delay_count = '0;
                    if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_data_hold = {r_data_hold[7:0], r_shift_byte};
                        n_phase     = PH_NK_SET;
                    end else begin
                        n_phase = PH_RX_HI;
                    end
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_NK_SET: begin
                res.scl = 1'b0;
                if (nk_hit) begin
                    n_phase = PH_NK_HI; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_NK_HI: begin
                if (hp_hit) begin
                    n_phase = PH_NK_LO; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_NK_LO: begin
                res.scl = 1'b0;
                if (hp_hit) begin
                    n_phase = PH_SP_PRE; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_SP_PRE: begin
                res.scl     = 1'b0;
                res.sda_out = 1'b0;
                if (hp_hit) begin
                    n_phase = PH_SP_A; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_SP_A: begin
                res.sda_out = 1'b0;
                if (hp_hit) begin
                    n_phase = PH_SP_B; n_delay_count = '0;
                end else n_delay_count = r_delay_count + 8'd1;
            end
            PH_SP_B: begin
                if (hp_hit) begin
                    n_delay_count = '0;
                    if (r_held_mode == i2cm_pkg::MODE_READ_PAIR && !r_pair_second) begin
                        n_pair_second   = 1'b1;
                        n_held_register = r_held_register + 8'd1;
                        n_byte_stage    = i2cm_pkg::STAGE_ADDR_W;
                        n_phase         = PH_ST_A;
                    end else begin
                        res.done_res  = 1'b1;
                        res.status    = r_fail_flag;
                        res.read_data = (r_held_mode == i2cm_pkg::MODE_WRITE) ? 16'd0
                                                                               : r_data_hold;
                        n_phase       = PH_IDLE;
                    end
                end else n_delay_count = r_delay_count + 8'd1;
            end
            default: begin
                n_phase       = PH_IDLE;
                n_delay_count = '0;
            end
        endcase

        // released line reads back as high
        if (!res.sda_oe) res.sda_out = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_bit_index       <= '0;
            r_shift_byte      <= '0;
            r_delay_count     <= '0;
            r_ack_wait_count  <= '0;
            r_data_hold       <= '0;
            r_held_mode       <= i2cm_pkg::MODE_NONE;
            r_held_register   <= '0;
            r_held_write_byte <= '0;
            r_pair_second     <= 1'b0;
            r_byte_stage      <= i2cm_pkg::STAGE_ADDR_W;
            r_fail_flag       <= 1'b0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_bit_index       <= n_bit_index;
            r_shift_byte      <= n_shift_byte;
            r_delay_count     <= n_delay_count;
            r_ack_wait_count  <= n_ack_wait_count;
            r_data_hold       <= n_data_hold;
            r_held_mode       <= n_held_mode;
            r_held_register   <= n_held_register;
            r_held_write_byte <= n_held_write_byte;
            r_pair_second     <= n_pair_second;
            r_byte_stage      <= n_byte_stage;
            r_fail_flag       <= n_fail_flag;
        end
    end

    assign o_res = res;

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.done_res |=> r_phase == PH_IDLE)
        else $error("done without return to idle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done_res |-> res.busy_res)
        else $error("done reported while idle");

    a_idle_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_delay_count == 8'd0)
        else $error("delay counter left running in idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= i2cm_pkg::BITS_PER_BYTE)
        else $error("bit index past one byte");

    a_write_no_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RX_HI || r_phase == PH_RX_LO) |-> r_held_mode != i2cm_pkg::MODE_WRITE)
        else $error("receive phase during a write command");

endmodule

/* design/i2c_master_register_access.sv */
// Top level of the I2C register access master: item and result registers.
//
// Each input item is one bus tick: a command field (used only while idle),
// the register address, the write byte and the sampled SDA level. Each item
// yields exactly one result item with the SCL/SDA drive for that tick, busy,
// and a one-tick done pulse with status and read data at the end of a
// command.
// An accepted item lands in the input register; once the output register
// is empty or being taken, the sequencer steps once and the result is
// loaded into the output register, raising o_out_valid. While results are
// taken, one item per cycle is sustained by one sequencer update per item.
// When the result is not taken, the output register holds it and the input
// register keeps its item; o_in_ready drops once both are full and rises
// again in the cycle the result is taken.
// Configuration is a plain write port (index 0 device address, 1 half
// period, 2 ack timeout) and applies at once. A synchronous reset empties
// both registers, returns the sequencer to idle and loads the default
// configuration.
module i2c_master_register_access (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_mode,
    input  logic [7:0]                          i_reg_addr,
    input  logic [7:0]                          i_write_data,
    input  logic                                i_sda_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_scl,
    output logic                                o_sda_out,
    output logic                                o_sda_oe,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic                                o_status,
    output logic [15:0]                         o_read_data,
    input  logic                                i_cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic                r_in_valid;
    i2cm_pkg::t_item     r_item;
    logic                r_out_valid;
    i2cm_pkg::t_result   r_res;
    logic                step;
    i2cm_pkg::t_cfg      cfg;
    i2cm_pkg::t_result   res;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    i2cm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (step) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.mode       <= i_mode;
            r_item.reg_addr   <= i_reg_addr;
            r_item.write_data <= i_write_data;
            r_item.sda_in     <= i_sda_in;
        end
        if (step) r_res <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_scl       = r_res.scl;
    assign o_sda_out   = r_res.sda_out;
    assign o_sda_oe    = r_res.sda_oe;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_status    = r_res.status;
    assign o_read_data = r_res.read_data;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the I2C register access master.
`timescale 1ns / 100ps

module testbench;

    // Bus sequencer phases, in the order the block walks through them
    typedef enum logic [4:0] {
        BUS_IDLE, BUS_START_A, BUS_START_B, BUS_TX_HI, BUS_TX_LO,
        BUS_ACK_REL, BUS_ACK_HI, BUS_ACK_POLL, BUS_ACK_LO, BUS_RX_HI,
        BUS_RX_LO, BUS_NACK_SET, BUS_NACK_HI, BUS_NACK_LO, BUS_STOP_PRE,
        BUS_STOP_A, BUS_STOP_B
    } t_bus_phase;

    typedef struct {
        t_bus_phase  phase;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [7:0]  delay_count;
        logic [7:0]  ack_wait_count;
        logic [15:0] data_hold;
        logic [1:0]  held_mode;
        logic [7:0]  held_register;
        logic [7:0]  held_write_byte;
        logic        pair_second;
        logic [1:0]  byte_stage;
        logic        fail_flag;
    } t_seq_state;

    localparam int ACK_ALWAYS = -1;

    logic                             i_clk;
    logic                             i_rst_n      = 1'b0;
    logic                             i_in_valid   = 1'b0;
    logic                             o_in_ready;
    logic [1:0]                       i_mode       = i2cm_pkg::MODE_NONE;
    logic [7:0]                       i_reg_addr   = 8'h00;
    logic [7:0]                       i_write_data = 8'h00;
    logic                             i_sda_in     = 1'b1;
    logic                             o_out_valid;
    logic                             i_out_ready  = 1'b0;
    logic                             o_scl;
    logic                             o_sda_out;
    logic                             o_sda_oe;
    logic                             o_busy_res;
    logic                             o_done_res;
    logic                             o_status;
    logic [15:0]                      o_read_data;
    logic                             i_cfg_we     = 1'b0;
    logic [i2cm_pkg::CFG_INDEX_W-1:0] i_cfg_index  = i2cm_pkg::CFG_DEVICE_ADDRESS;
    logic [i2cm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata  = '0;

    t_seq_state          plan_state;
    t_seq_state          chk_state;
    i2cm_pkg::t_cfg      plan_cfg;
    i2cm_pkg::t_cfg      chk_cfg;
    i2cm_pkg::t_item     ticks_to_send[$];
    i2cm_pkg::t_result   tick_results_due[$];
    i2cm_pkg::t_item     next_tick;
    i2cm_pkg::t_item     taken;
    i2cm_pkg::t_result   seen;

    logic          tick_taken = 1'b0;
    bit            calm = 1'b0;
    int            send_gap = 0;
    int            take_gap = 0;
    int            planned_count = 0;
    int            accepted_count = 0;
    int            results_seen = 0;
    int            mismatch_count = 0;
    int            writes_issued = 0;
    int            reads_issued = 0;
    int            pairs_issued = 0;
    int            commands_done = 0;
    int            acks_missed = 0;
    int            settings_used = 0;

    i2c_master_register_access dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scl        (o_scl),
        .o_sda_out    (o_sda_out),
        .o_sda_oe     (o_sda_oe),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .o_read_data  (o_read_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- sequencer prediction ----------------

    function automatic t_seq_state seq_reset();
        t_seq_state s;
        s.phase = BUS_IDLE;
        s.bit_index = '0;
        s.shift_byte = '0;
        s.delay_count = '0;
        s.ack_wait_count = '0;
        s.data_hold = '0;
        s.held_mode = i2cm_pkg::MODE_NONE;
        s.held_register = '0;
        s.held_write_byte = '0;
        s.pair_second = 1'b0;
        s.byte_stage = i2cm_pkg::STAGE_ADDR_W;
        s.fail_flag = 1'b0;
        return s;
    endfunction

    function automatic void enter_phase(inout t_seq_state s, input t_bus_phase p);
        s.phase = p;
        s.delay_count = '0;
    endfunction

    // true on the last tick of a timed interval, else counts one tick
    function automatic bit span_over(inout t_seq_state s, input int unsigned len);
        if (32'(s.delay_count) + 1 >= len) return 1'b1;
        s.delay_count = s.delay_count + 8'd1;
        return 1'b0;
    endfunction

    function automatic void load_byte(inout t_seq_state s, input logic [7:0] b);
        s.shift_byte = b;
        s.bit_index = '0;
        enter_phase(s, BUS_TX_HI);
    endfunction

    function automatic i2cm_pkg::t_result sequencer_tick(inout t_seq_state s,
                                                         input i2cm_pkg::t_cfg c,
                                                         input i2cm_pkg::t_item it);
        i2cm_pkg::t_result r;
        int unsigned       hp;
        hp = (c.half_period_ticks == 8'd0) ? 32'd1 : 32'(c.half_period_ticks);
        r = '0;
        r.scl = 1'b1;
        r.sda_out = 1'b1;
        r.sda_oe = 1'b1;
        r.busy_res = (s.phase != BUS_IDLE);
        case (s.phase)
            BUS_IDLE: begin
                if (it.mode != i2cm_pkg::MODE_NONE) begin
                    s.held_mode = it.mode;
                    s.held_register = it.reg_addr;
                    s.held_write_byte = it.write_data;
                    s.pair_second = 1'b0;
                    s.data_hold = '0;
                    s.fail_flag = 1'b0;
                    s.byte_stage = i2cm_pkg::STAGE_ADDR_W;
                    enter_phase(s, BUS_START_A);
                end
            end
            BUS_START_A: begin
                if (span_over(s, hp)) enter_phase(s, BUS_START_B);
            end
            BUS_START_B: begin
                r.sda_out = 1'b0;
                if (span_over(s, hp))
                    load_byte(s, {c.device_address, s.byte_stage == i2cm_pkg::STAGE_DATA});
            end
            BUS_TX_HI: begin
                r.sda_out = (s.shift_byte & i2cm_pkg::MSB_MASK) != 8'h00;
                if (span_over(s, hp)) enter_phase(s, BUS_TX_LO);
            end
            BUS_TX_LO: begin
                r.scl = 1'b0;
                r.sda_out = (s.shift_byte & i2cm_pkg::MSB_MASK) != 8'h00;
                if (span_over(s, hp)) begin
                    s.shift_byte = s.shift_byte << 1;
                    s.bit_index = s.bit_index + 4'd1;
                    enter_phase(s, (s.bit_index >= i2cm_pkg::BITS_PER_BYTE) ? BUS_ACK_REL
                                                                             : BUS_TX_HI);
                end
            end
            BUS_ACK_REL: begin
                r.scl = 1'b0;
                if (span_over(s, hp)) enter_phase(s, BUS_ACK_HI);
            end
            BUS_ACK_HI: begin
                r.sda_oe = 1'b0;
                if (span_over(s, hp)) begin
                    s.ack_wait_count = '0;
                    enter_phase(s, BUS_ACK_POLL);
                end
            end
            BUS_ACK_POLL: begin
                r.sda_oe = 1'b0;
                if (!it.sda_in) begin
                    enter_phase(s, BUS_ACK_LO);
                end else if (s.ack_wait_count >= c.ack_timeout_ticks) begin
                    s.fail_flag = 1'b1;
                    // an aborted read half contributes a zero byte
                    if (s.held_mode != i2cm_pkg::MODE_WRITE) s.data_hold = s.data_hold << 8;
                    enter_phase(s, BUS_STOP_PRE);
                end else begin
                    s.ack_wait_count = s.ack_wait_count + 8'd1;
                end
            end
            BUS_ACK_LO: begin
                r.scl = 1'b0;
                r.sda_oe = 1'b0;
                if (span_over(s, hp)) begin
                    if (s.byte_stage == i2cm_pkg::STAGE_ADDR_W) begin
                        s.byte_stage = i2cm_pkg::STAGE_REG;
                        load_byte(s, s.held_register);
                    end else if (s.byte_stage == i2cm_pkg::STAGE_REG) begin
                        s.byte_stage = i2cm_pkg::STAGE_DATA;
                        if (s.held_mode == i2cm_pkg::MODE_WRITE)
                            load_byte(s, s.held_write_byte);
                        else enter_phase(s, BUS_START_A);
                    end else if (s.held_mode == i2cm_pkg::MODE_WRITE) begin
                        enter_phase(s, BUS_STOP_PRE);
                    end else begin
                        s.shift_byte = '0;
                        s.bit_index = '0;
                        enter_phase(s, BUS_RX_HI);
                    end
                end
            end
            BUS_RX_HI: begin
                r.sda_oe = 1'b0;
                if (span_over(s, hp)) begin
                    s.shift_byte = {s.shift_byte[6:0], it.sda_in};
                    enter_phase(s, BUS_RX_LO);
                end
            end
            BUS_RX_LO: begin
                r.scl = 1'b0;
                r.sda_oe = 1'b0;
                if (span_over(s, hp)) begin
                    s.bit_index = s.bit_index + 4'd1;
                    if (s.bit_index >= i2cm_pkg::BITS_PER_BYTE) begin
                        s.data_hold = {s.data_hold[7:0], s.shift_byte};
                        enter_phase(s, BUS_NACK_SET);
                    end else begin
                        enter_phase(s, BUS_RX_HI);
                    end
                end
            end
            BUS_NACK_SET: begin
                r.scl = 1'b0;
                if (span_over(s, 32'(i2cm_pkg::NACK_SETUP_TICKS)))
                    enter_phase(s, BUS_NACK_HI);
            end
            BUS_NACK_HI: begin
                if (span_over(s, hp)) enter_phase(s, BUS_NACK_LO);
            end
            BUS_NACK_LO: begin
                r.scl = 1'b0;
                if (span_over(s, hp)) enter_phase(s, BUS_STOP_PRE);
            end
            BUS_STOP_PRE: begin
                r.scl = 1'b0;
                r.sda_out = 1'b0;
                if (span_over(s, hp)) enter_phase(s, BUS_STOP_A);
            end
            BUS_STOP_A: begin
                r.sda_out = 1'b0;
                if (span_over(s, hp)) enter_phase(s, BUS_STOP_B);
            end
            BUS_STOP_B: begin
                if (span_over(s, hp)) begin
                    if (s.held_mode == i2cm_pkg::MODE_READ_PAIR && !s.pair_second) begin
                        s.pair_second = 1'b1;
                        s.held_register = s.held_register + 8'd1;
                        s.byte_stage = i2cm_pkg::STAGE_ADDR_W;
                        enter_phase(s, BUS_START_A);
                    end else begin
                        r.done_res = 1'b1;
                        r.status = s.fail_flag;
                        r.read_data = (s.held_mode == i2cm_pkg::MODE_WRITE) ? 16'h0000
                                                                            : s.data_hold;
                        enter_phase(s, BUS_IDLE);
                    end
                end
            end
            default: enter_phase(s, BUS_IDLE);
        endcase
        if (!r.sda_oe) r.sda_out = 1'b1;
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("%0t: result %0d %s got %h want %h", $time, results_seen, what, got, want);
    endtask

    task automatic compare_result(input i2cm_pkg::t_result got,
                                  input i2cm_pkg::t_result want);
        if (got.scl !== want.scl)
            report_mismatch("scl", 16'(got.scl), 16'(want.scl));
        if (got.sda_out !== want.sda_out)
            report_mismatch("sda_out", 16'(got.sda_out), 16'(want.sda_out));
        if (got.sda_oe !== want.sda_oe)
            report_mismatch("sda_oe", 16'(got.sda_oe), 16'(want.sda_oe));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy", 16'(got.busy_res), 16'(want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch("done", 16'(got.done_res), 16'(want.done_res));
        if (got.status !== want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_taken <= 1'b0;
        end else begin
            tick_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                seen.scl = o_scl;
                seen.sda_out = o_sda_out;
                seen.sda_oe = o_sda_oe;
                seen.busy_res = o_busy_res;
                seen.done_res = o_done_res;
                seen.status = o_status;
                seen.read_data = o_read_data;
                if (tick_results_due.size() == 0)
                    report_mismatch("arrived with nothing expected", '0, '0);
                else
                    compare_result(seen, tick_results_due.pop_front());
                results_seen++;
            end
            if (i_in_valid && o_in_ready) begin
                taken.mode = i_mode;
                taken.reg_addr = i_reg_addr;
                taken.write_data = i_write_data;
                taken.sda_in = i_sda_in;
                tick_results_due.push_back(sequencer_tick(chk_state, chk_cfg, taken));
                if (tick_results_due[$].done_res) begin
                    commands_done++;
                    if (tick_results_due[$].status) acks_missed++;
                end
                accepted_count++;
            end
        end
    end

    // ---------------- driving ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || tick_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                send_gap <= $urandom_range(0, 11);
                i_in_valid <= 1'b0;
            end else if (ticks_to_send.size() != 0) begin
                next_tick = ticks_to_send.pop_front();
                i_mode <= next_tick.mode;
                i_reg_addr <= next_tick.reg_addr;
                i_write_data <= next_tick.write_data;
                i_sda_in <= next_tick.sda_in;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            take_gap <= $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------- stimulus planning ----------------

    task automatic push_tick(input logic [1:0] cmd, input logic [7:0] rg,
                             input logic [7:0] wd, input logic sda);
        i2cm_pkg::t_item it;
        it.mode = cmd;
        it.reg_addr = rg;
        it.write_data = wd;
        it.sda_in = sda;
        void'(sequencer_tick(plan_state, plan_cfg, it));
        ticks_to_send.push_back(it);
        planned_count++;
    endtask

    task automatic plan_idle(input int n);
        repeat (n)
            push_tick(i2cm_pkg::MODE_NONE, 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)));
    endtask

    // One command from idle back to idle; the target holds SDA high on
    // acknowledge slot mute_at, so that byte times out.
    task automatic plan_command(input logic [1:0] cmd, input logic [7:0] rg,
                                input logic [7:0] wd, input int mute_at);
        int   ack_slot;
        logic sda;
        logic polling;
        ack_slot = 0;
        push_tick(cmd, rg, wd, 1'($urandom_range(0, 1)));
        while (plan_state.phase != BUS_IDLE) begin
            polling = (plan_state.phase == BUS_ACK_POLL);
            if (polling && ack_slot == mute_at) sda = 1'b1;
            else if (polling) sda = ($urandom_range(0, 99) < 80) ? 1'b0 : 1'b1;
            else sda = 1'($urandom_range(0, 1));
            // mode is ignored while busy, so it gets random codes here
            push_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), sda);
            if (polling && plan_state.phase != BUS_ACK_POLL) ack_slot++;
        end
        case (cmd)
            i2cm_pkg::MODE_WRITE:     writes_issued++;
            i2cm_pkg::MODE_READ:      reads_issued++;
            i2cm_pkg::MODE_READ_PAIR: pairs_issued++;
            default: ;
        endcase
    endtask

    task automatic plan_random_command();
        logic [1:0] cmd;
        logic [7:0] rg;
        int         mute_at;
        cmd = 2'($urandom_range(1, 3));
        case ($urandom_range(0, 7))
            0:       rg = 8'h00;
            1:       rg = 8'hFF;
            default: rg = 8'($urandom);
        endcase
        mute_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : ACK_ALWAYS;
        plan_command(cmd, rg, 8'($urandom), mute_at);
        plan_idle($urandom_range(0, 3));
    endtask

    task automatic plan_random_ticks(input int n);
        int start;
        start = planned_count;
        while (planned_count - start < n) plan_random_command();
    endtask

    // sender holds off until every planned tick has come back
    task automatic drain();
        while (accepted_count != planned_count || tick_results_due.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [i2cm_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [i2cm_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            i2cm_pkg::CFG_DEVICE_ADDRESS:    chk_cfg.device_address = val[6:0];
            i2cm_pkg::CFG_HALF_PERIOD_TICKS: chk_cfg.half_period_ticks = val;
            i2cm_pkg::CFG_ACK_TIMEOUT_TICKS: chk_cfg.ack_timeout_ticks = val;
            default: ;
        endcase
        plan_cfg = chk_cfg;
    endtask

    task automatic apply_settings(input logic [6:0] addr, input logic [7:0] half,
                                  input logic [7:0] limit);
        logic top;
        top = 1'($urandom_range(0, 1));   // bit 7 of the address write is dropped
        write_register(i2cm_pkg::CFG_DEVICE_ADDRESS, {top, addr});
        write_register(i2cm_pkg::CFG_HALF_PERIOD_TICKS, half);
        write_register(i2cm_pkg::CFG_ACK_TIMEOUT_TICKS, limit);
        settings_used++;
    endtask

    initial begin
        plan_state = seq_reset();
        chk_state = seq_reset();
        chk_cfg.device_address = i2cm_pkg::RST_DEVICE_ADDRESS;
        chk_cfg.half_period_ticks = i2cm_pkg::RST_HALF_PERIOD_TICKS;
        chk_cfg.ack_timeout_ticks = i2cm_pkg::RST_ACK_TIMEOUT_TICKS;
        plan_cfg = chk_cfg;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // settings out of reset: one full write
        plan_idle(3);
        plan_command(i2cm_pkg::MODE_WRITE, 8'h00, 8'hFF, ACK_ALWAYS);
        plan_idle(2);
        drain();

        // shortest timing: field extremes, wrapping pair, aborts in each command kind
        apply_settings(7'h00, 8'd1, 8'd1);
        plan_command(i2cm_pkg::MODE_WRITE, 8'hFF, 8'h00, ACK_ALWAYS);
        plan_command(i2cm_pkg::MODE_READ, 8'hFF, 8'h00, ACK_ALWAYS);
        plan_command(i2cm_pkg::MODE_READ_PAIR, 8'hFF, 8'h5A, ACK_ALWAYS);
        plan_command(i2cm_pkg::MODE_WRITE, 8'hFF, 8'h00, 0);
        plan_command(i2cm_pkg::MODE_WRITE, 8'h81, 8'h7E, 2);
        plan_command(i2cm_pkg::MODE_READ, 8'h3C, 8'hA5, 2);
        plan_command(i2cm_pkg::MODE_READ_PAIR, 8'h10, 8'h00, 1);
        plan_command(i2cm_pkg::MODE_READ_PAIR, 8'hC3, 8'h00, 5);
        plan_idle(2);
        drain();

        // zero half period runs as one tick; longest ack wait
        apply_settings(7'h7F, 8'd0, 8'd255);
        plan_command(i2cm_pkg::MODE_WRITE, 8'($urandom), 8'($urandom), ACK_ALWAYS);
        plan_command(i2cm_pkg::MODE_WRITE, 8'($urandom), 8'($urandom), 0);
        drain();

        apply_settings(7'($urandom), 8'd2, 8'($urandom_range(1, 12)));
        plan_random_ticks(80);
        drain();

        calm = 1'b1;
        apply_settings(7'($urandom), 8'd1, 8'($urandom_range(1, 8)));
        plan_random_ticks(100);
        drain();

        $display("Ran %0d bus ticks: %0d writes, %0d reads, %0d pair reads issued",
                 accepted_count, writes_issued, reads_issued, pairs_issued);
        $display("%0d commands completed, %0d with a missing ack, over %0d bus settings",
                 commands_done, acks_missed, settings_used);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("Timed out with %0d results outstanding", tick_results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
design/i2cm_pkg.sv
design/i2cm_cfg.sv
design/i2cm_seq.sv
design/i2c_master_register_access.sv
tb/testbench.sv
